// ===== hdl/gmsc_pkg.sv =====
// ----------------------------------------------------------------------------
// gmsc_pkg
// Types and constants shared by the motion stream checker modules.
// ----------------------------------------------------------------------------
package gmsc_pkg;

  localparam logic [3:0] CMD_OTHER      = 4'd0;
  localparam logic [3:0] CMD_LAYER      = 4'd1;
  localparam logic [3:0] CMD_BAD_MARK   = 4'd2;
  localparam logic [3:0] CMD_ABS_XYZ    = 4'd3;
  localparam logic [3:0] CMD_REL_XYZ    = 4'd4;
  localparam logic [3:0] CMD_ABS_E      = 4'd5;
  localparam logic [3:0] CMD_REL_E      = 4'd6;
  localparam logic [3:0] CMD_HOME       = 4'd7;
  localparam logic [3:0] CMD_SET_POS    = 4'd8;
  localparam logic [3:0] CMD_NOZZLE     = 4'd9;
  localparam logic [3:0] CMD_BED        = 4'd10;
  localparam logic [3:0] CMD_MOTORS_OFF = 4'd11;
  localparam logic [3:0] CMD_RESET      = 4'd12;
  localparam logic [3:0] CMD_MOVE       = 4'd13;
  localparam logic [3:0] CMD_END        = 4'd14;

  localparam logic [3:0] ISS_LAYER_ORDER  = 4'd1;
  localparam logic [3:0] ISS_BAD_MARKER   = 4'd2;
  localparam logic [3:0] ISS_NOZZLE       = 4'd3;
  localparam logic [3:0] ISS_BED          = 4'd4;
  localparam logic [3:0] ISS_RESET        = 4'd5;
  localparam logic [3:0] ISS_VOLUME       = 4'd6;
  localparam logic [3:0] ISS_FEED         = 4'd7;
  localparam logic [3:0] ISS_Z_BACK       = 4'd8;
  localparam logic [3:0] ISS_NO_HOME      = 4'd9;
  localparam logic [3:0] ISS_NO_MOTION    = 4'd10;
  localparam logic [3:0] ISS_NO_LAYER     = 4'd11;
  localparam logic [3:0] ISS_NO_EXTRUSION = 4'd12;
  localparam logic [3:0] ISS_NO_LAYERS    = 4'd13;
  localparam logic [3:0] ISS_NO_END       = 4'd14;
  localparam logic [3:0] ISS_DONE         = 4'd15;

  localparam int SEEN_HOME   = 0;
  localparam int SEEN_MOTION = 1;
  localparam int SEEN_LAYER  = 2;
  localparam int SEEN_EXTR   = 3;
  localparam int SEEN_END    = 4;

  localparam logic [2:0] REG_VOLUME_WIDTH  = 3'd0;
  localparam logic [2:0] REG_VOLUME_DEPTH  = 3'd1;
  localparam logic [2:0] REG_VOLUME_HEIGHT = 3'd2;
  localparam logic [2:0] REG_NOZZLE_LIMIT  = 3'd3;
  localparam logic [2:0] REG_BED_LIMIT     = 3'd4;
  localparam logic [2:0] REG_TRAVEL_LIMIT  = 3'd5;

  localparam logic [30:0] RST_VOLUME_WIDTH  = 31'd220000;
  localparam logic [30:0] RST_VOLUME_DEPTH  = 31'd220000;
  localparam logic [30:0] RST_VOLUME_HEIGHT = 31'd250000;
  localparam logic [19:0] RST_NOZZLE_LIMIT  = 20'd260000;
  localparam logic [19:0] RST_BED_LIMIT     = 20'd100000;
  localparam logic [25:0] RST_TRAVEL_LIMIT  = 26'd200000;

  typedef struct packed {
    logic [3:0]         command;
    logic               has_x;
    logic signed [31:0] x_pos;
    logic               has_y;
    logic signed [31:0] y_pos;
    logic               has_z;
    logic signed [31:0] z_pos;
    logic               has_e;
    logic signed [31:0] e_pos;
    logic               has_value;
    logic signed [31:0] word_value;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  issue_code;
    logic [30:0] line_number;
    logic        overall_ok;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [30:0] volume_width;
    logic [30:0] volume_depth;
    logic [30:0] volume_height;
    logic [19:0] nozzle_temp_limit;
    logic [19:0] bed_temp_limit;
    logic [25:0] travel_speed_limit;
  } cfg_t;

  typedef struct packed {
    logic [15:1] mask;
    logic [30:0] line;
    logic        ok;
  } job_t;

endpackage

// ===== hdl/gmsc_front.sv =====
// ----------------------------------------------------------------------------
// gmsc_front
// Accepts program lines, tracks position, modes and flags, and classifies
// each line into a set of issue codes for the result queue.
// ----------------------------------------------------------------------------
module gmsc_front
  import gmsc_pkg::*;
#(
  parameter int COORD_BITS = 32
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_item_t in_data_i,
  input  cfg_t     cfg_i,
  output logic     push_valid_o,
  input  logic     push_ready_i,
  output job_t     push_data_o
);

  localparam int CW = COORD_BITS;
  localparam int WW = (CW > 32) ? CW : 32;
  localparam int SW = CW + 1;
  localparam logic signed [CW-1:0] MAXC = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] MINC = {1'b1, {(CW-1){1'b0}}};

  function automatic logic signed [CW-1:0] sat_word(input logic signed [WW-1:0] v);
    logic [WW-CW:0] top;
    top = v[WW-1:CW-1];
    if ((&top) || !(|top)) begin
      sat_word = v[CW-1:0];
    end else begin
      sat_word = v[WW-1] ? MINC : MAXC;
    end
  endfunction

  function automatic logic signed [CW-1:0] sat_sum(input logic signed [SW-1:0] v);
    if (v[SW-1] == v[SW-2]) begin
      sat_sum = v[CW-1:0];
    end else begin
      sat_sum = v[SW-1] ? MINC : MAXC;
    end
  endfunction

  // stage 1: held transaction
  logic     s1_valid_q, s1_valid_d;
  in_item_t s1_item_q;

  // program state owned by stage 1
  logic signed [CW-1:0] pos_x_q, pos_x_d, pos_y_q, pos_y_d;
  logic signed [CW-1:0] pos_z_q, pos_z_d, pos_e_q, pos_e_d;
  logic signed [31:0]   prev_layer_q, prev_layer_d;
  logic [30:0]          line_q, line_d;
  logic [1:0]           mode_q, mode_d;
  logic [4:0]           seen_q, seen_d;

  // stage 2
  logic                 s2_valid_q, s2_valid_d;
  logic                 s2_move_q, s2_move_d, s2_end_q, s2_end_d, s2_hz_q, s2_hz_d;
  logic signed [CW-1:0] s2_nx_q, s2_nx_d, s2_ny_q, s2_ny_d, s2_nz_q, s2_nz_d;
  logic [15:1]          s2_mask_q, s2_mask_d;
  logic [30:0]          s2_line_q, s2_line_d;

  // state owned by stage 2
  logic signed [CW-1:0] highest_z_q, highest_z_d;
  logic                 issue_q, issue_d;

  logic                 s1_fire, s2_ready, s2_fire;
  logic [3:0]           cmd;
  logic signed [31:0]   wv;
  logic signed [CW-1:0] wx, wy, wz, we, nx, ny, nz, ne;
  logic [31:0]          feed_limit;
  logic                 feed_bad;
  logic [15:1]          mask_full;
  logic signed [WW-1:0] vol_w, vol_d, vol_h, ext_x, ext_y, ext_z;
  logic                 outside;

  assign cmd = s1_item_q.command;
  assign wv  = s1_item_q.word_value;
  assign wx  = sat_word(WW'(s1_item_q.x_pos));
  assign wy  = sat_word(WW'(s1_item_q.y_pos));
  assign wz  = sat_word(WW'(s1_item_q.z_pos));
  assign we  = sat_word(WW'(s1_item_q.e_pos));

  assign nx = !s1_item_q.has_x ? pos_x_q :
              (mode_q[0] ? wx : sat_sum(SW'(pos_x_q) + SW'(wx)));
  assign ny = !s1_item_q.has_y ? pos_y_q :
              (mode_q[0] ? wy : sat_sum(SW'(pos_y_q) + SW'(wy)));
  assign nz = !s1_item_q.has_z ? pos_z_q :
              (mode_q[0] ? wz : sat_sum(SW'(pos_z_q) + SW'(wz)));
  assign ne = !s1_item_q.has_e ? pos_e_q :
              (mode_q[1] ? we : sat_sum(SW'(pos_e_q) + SW'(we)));

  assign feed_limit = (32'(cfg_i.travel_speed_limit) << 6)
                    - (32'(cfg_i.travel_speed_limit) << 2);
  assign feed_bad   = wv[31] || (wv == 32'sd0) || ($unsigned(wv) > feed_limit);

  assign s2_fire    = s2_valid_q && s2_ready;
  assign s1_fire    = s1_valid_q && s2_ready;
  assign in_ready_o = !s1_valid_q || s2_ready;

  always_comb begin
    pos_x_d      = pos_x_q;
    pos_y_d      = pos_y_q;
    pos_z_d      = pos_z_q;
    pos_e_d      = pos_e_q;
    prev_layer_d = prev_layer_q;
    line_d       = line_q;
    mode_d       = mode_q;
    seen_d       = seen_q;
    s2_move_d    = 1'b0;
    s2_end_d     = 1'b0;
    s2_hz_d      = s1_item_q.has_z;
    s2_nx_d      = nx;
    s2_ny_d      = ny;
    s2_nz_d      = nz;
    s2_mask_d    = '0;

    if (cmd != CMD_END && line_q != '1) begin
      line_d = line_q + 31'd1;
    end
    s2_line_d = (cmd == CMD_END) ? '0 : line_d;

    case (cmd)
      CMD_LAYER: begin
        seen_d[SEEN_LAYER] = 1'b1;
        if (wv <= prev_layer_q) begin
          s2_mask_d[ISS_LAYER_ORDER] = 1'b1;
        end
        prev_layer_d = wv;
      end
      CMD_BAD_MARK: begin
        seen_d[SEEN_LAYER]        = 1'b1;
        s2_mask_d[ISS_BAD_MARKER] = 1'b1;
      end
      CMD_ABS_XYZ: mode_d[0] = 1'b1;
      CMD_REL_XYZ: mode_d[0] = 1'b0;
      CMD_ABS_E:   mode_d[1] = 1'b1;
      CMD_REL_E:   mode_d[1] = 1'b0;
      CMD_HOME:    seen_d[SEEN_HOME] = 1'b1;
      CMD_SET_POS: begin
        if (s1_item_q.has_x) pos_x_d = wx;
        if (s1_item_q.has_y) pos_y_d = wy;
        if (s1_item_q.has_z) pos_z_d = wz;
        if (s1_item_q.has_e) pos_e_d = we;
      end
      CMD_NOZZLE: begin
        if (s1_item_q.has_value &&
            (wv[31] || (wv[30:0] > 31'(cfg_i.nozzle_temp_limit)))) begin
          s2_mask_d[ISS_NOZZLE] = 1'b1;
        end
      end
      CMD_BED: begin
        if (s1_item_q.has_value &&
            (wv[31] || (wv[30:0] > 31'(cfg_i.bed_temp_limit)))) begin
          s2_mask_d[ISS_BED] = 1'b1;
        end
      end
      CMD_MOTORS_OFF: seen_d[SEEN_END] = 1'b1;
      CMD_RESET:      s2_mask_d[ISS_RESET] = 1'b1;
      CMD_MOVE: begin
        s2_move_d           = 1'b1;
        seen_d[SEEN_MOTION] = 1'b1;
        if (s1_item_q.has_value && feed_bad) begin
          s2_mask_d[ISS_FEED] = 1'b1;
        end
        if (s1_item_q.has_e && (ne != pos_e_q)) begin
          seen_d[SEEN_EXTR] = 1'b1;
        end
        pos_x_d = nx;
        pos_y_d = ny;
        pos_z_d = nz;
        pos_e_d = ne;
      end
      CMD_END: begin
        s2_end_d                    = 1'b1;
        s2_mask_d[ISS_NO_HOME]      = !seen_q[SEEN_HOME];
        s2_mask_d[ISS_NO_MOTION]    = !seen_q[SEEN_MOTION];
        s2_mask_d[ISS_NO_LAYER]     = !seen_q[SEEN_LAYER];
        s2_mask_d[ISS_NO_EXTRUSION] = !seen_q[SEEN_EXTR];
        s2_mask_d[ISS_NO_LAYERS]    = !seen_q[SEEN_LAYER];
        s2_mask_d[ISS_NO_END]       = !seen_q[SEEN_END];
        pos_x_d      = '0;
        pos_y_d      = '0;
        pos_z_d      = '0;
        pos_e_d      = '0;
        prev_layer_d = -32'sd1;
        line_d       = '0;
        mode_d       = 2'b11;
        seen_d       = '0;
      end
      default: begin
      end
    endcase
  end

  assign vol_w = WW'($signed({1'b0, cfg_i.volume_width}));
  assign vol_d = WW'($signed({1'b0, cfg_i.volume_depth}));
  assign vol_h = WW'($signed({1'b0, cfg_i.volume_height}));
  assign ext_x = WW'(s2_nx_q);
  assign ext_y = WW'(s2_ny_q);
  assign ext_z = WW'(s2_nz_q);
  assign outside = s2_nx_q[CW-1] || s2_ny_q[CW-1] || s2_nz_q[CW-1] ||
                   (ext_x > vol_w) || (ext_y > vol_d) || (ext_z > vol_h);

  always_comb begin
    mask_full = s2_mask_q;
    if (s2_move_q) begin
      mask_full[ISS_VOLUME] = outside;
      mask_full[ISS_Z_BACK] = s2_hz_q && (s2_nz_q < highest_z_q);
    end
    if (s2_end_q) begin
      mask_full[ISS_DONE] = 1'b1;
    end
  end

  assign push_valid_o     = s2_valid_q && (|mask_full);
  assign push_data_o.mask = mask_full;
  assign push_data_o.line = s2_line_q;
  assign push_data_o.ok   = !(issue_q || (|s2_mask_q[14:1]));
  assign s2_ready         = !s2_valid_q || !(|mask_full) || push_ready_i;

  always_comb begin
    highest_z_d = highest_z_q;
    issue_d     = issue_q;
    if (s2_fire) begin
      if (s2_end_q) begin
        highest_z_d = '0;
        issue_d     = 1'b0;
      end else begin
        if (|mask_full[8:1]) issue_d = 1'b1;
        if (s2_move_q && (s2_nz_q > highest_z_q)) highest_z_d = s2_nz_q;
      end
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_valid_i && in_ready_o) begin
      s1_valid_d = 1'b1;
    end else if (s1_fire) begin
      s1_valid_d = 1'b0;
    end
    s2_valid_d = s2_valid_q;
    if (s1_fire) begin
      s2_valid_d = 1'b1;
    end else if (s2_fire) begin
      s2_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      s2_valid_q   <= 1'b0;
      pos_x_q      <= '0;
      pos_y_q      <= '0;
      pos_z_q      <= '0;
      pos_e_q      <= '0;
      prev_layer_q <= -32'sd1;
      line_q       <= '0;
      mode_q       <= 2'b11;
      seen_q       <= '0;
      highest_z_q  <= '0;
      issue_q      <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      s2_valid_q  <= s2_valid_d;
      highest_z_q <= highest_z_d;
      issue_q     <= issue_d;
      if (s1_fire) begin
        pos_x_q      <= pos_x_d;
        pos_y_q      <= pos_y_d;
        pos_z_q      <= pos_z_d;
        pos_e_q      <= pos_e_d;
        prev_layer_q <= prev_layer_d;
        line_q       <= line_d;
        mode_q       <= mode_d;
        seen_q       <= seen_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_item_q <= in_data_i;
    end
    if (s1_fire) begin
      s2_move_q <= s2_move_d;
      s2_end_q  <= s2_end_d;
      s2_hz_q   <= s2_hz_d;
      s2_nx_q   <= s2_nx_d;
      s2_ny_q   <= s2_ny_d;
      s2_nz_q   <= s2_nz_d;
      s2_mask_q <= s2_mask_d;
      s2_line_q <= s2_line_d;
    end
  end

endmodule

// ===== hdl/gmsc_queue.sv =====
// ----------------------------------------------------------------------------
// gmsc_queue
// Short first-in first-out queue of classified lines between front and back.
// ----------------------------------------------------------------------------
module gmsc_queue
  import gmsc_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  job_t push_data_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output job_t pop_data_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  job_t            mem_q [DEPTH];
  logic [AW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNTW-1:0] count_q, count_d;
  logic            push_fire, pop_fire;

  assign push_ready_o = (count_q != CNTW'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push_fire    = push_valid_i && push_ready_o;
  assign pop_fire     = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_fire) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_fire) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_fire && !pop_fire) begin
      count_d = count_q + 1'b1;
    end else if (pop_fire && !push_fire) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_fire) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== hdl/gmsc_back.sv =====
// ----------------------------------------------------------------------------
// gmsc_back
// Expands one queued line into its results, lowest issue code first.
// ----------------------------------------------------------------------------
module gmsc_back
  import gmsc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      pop_valid_i,
  output logic      pop_ready_o,
  input  job_t      pop_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  logic [15:1] mask_q, mask_d, rest;
  logic [30:0] line_q;
  logic        ok_q;
  logic [3:0]  code;
  logic        out_fire, take;

  always_comb begin
    code = ISS_DONE;
    for (int i = 15; i >= 1; i--) begin
      if (mask_q[i]) code = 4'(i);
    end
  end

  assign rest        = mask_q & (mask_q - 15'd1);
  assign out_valid_o = |mask_q;
  assign out_fire    = out_valid_o && out_ready_i;
  assign take        = !(|mask_q) || (out_fire && !(|rest));
  assign pop_ready_o = take;

  assign out_data_o.issue_code  = code;
  assign out_data_o.line_number = line_q;
  assign out_data_o.overall_ok  = (code == ISS_DONE) && ok_q;
  assign out_data_o.last        = !(|rest);

  always_comb begin
    mask_d = mask_q;
    if (out_fire) mask_d = rest;
    if (take && pop_valid_i) mask_d = pop_data_i.mask;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else begin
      mask_q <= mask_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && pop_valid_i) begin
      line_q <= pop_data_i.line;
      ok_q   <= pop_data_i.ok;
    end
  end

endmodule

// ===== hdl/gcode_motion_stream_checker.sv =====
// ----------------------------------------------------------------------------
// gcode_motion_stream_checker
// Checks a stream of pre-parsed motion-program lines and reports issues.
// ----------------------------------------------------------------------------
// One program line is taken per clock cycle; input stalls only once the queue
// fills. Each line passes a two-stage front: the first stage updates position,
// modes, layer number and line count with a saturating add per axis, the
// second checks the build volume and the highest Z. A line that raises issues
// lands in a queue of QUEUE_DEPTH entries and the back end sends its results
// one per cycle while out_ready_i is high, so an end line yields up to seven
// results. Registers sit at byte addresses 0 to 20 of the configuration port.
module gcode_motion_stream_checker
  import gmsc_pkg::*;
#(
  parameter int COORD_BITS  = 32,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t cfg_q;
  logic cfg_write;
  logic push_valid, push_ready, pop_valid, pop_ready;
  job_t push_data, pop_data;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.volume_width       <= RST_VOLUME_WIDTH;
      cfg_q.volume_depth       <= RST_VOLUME_DEPTH;
      cfg_q.volume_height      <= RST_VOLUME_HEIGHT;
      cfg_q.nozzle_temp_limit  <= RST_NOZZLE_LIMIT;
      cfg_q.bed_temp_limit     <= RST_BED_LIMIT;
      cfg_q.travel_speed_limit <= RST_TRAVEL_LIMIT;
    end else if (cfg_write) begin
      case (paddr[4:2])
        REG_VOLUME_WIDTH:  cfg_q.volume_width       <= pwdata[30:0];
        REG_VOLUME_DEPTH:  cfg_q.volume_depth       <= pwdata[30:0];
        REG_VOLUME_HEIGHT: cfg_q.volume_height      <= pwdata[30:0];
        REG_NOZZLE_LIMIT:  cfg_q.nozzle_temp_limit  <= pwdata[19:0];
        REG_BED_LIMIT:     cfg_q.bed_temp_limit     <= pwdata[19:0];
        REG_TRAVEL_LIMIT:  cfg_q.travel_speed_limit <= pwdata[25:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_VOLUME_WIDTH:  prdata = 32'(cfg_q.volume_width);
      REG_VOLUME_DEPTH:  prdata = 32'(cfg_q.volume_depth);
      REG_VOLUME_HEIGHT: prdata = 32'(cfg_q.volume_height);
      REG_NOZZLE_LIMIT:  prdata = 32'(cfg_q.nozzle_temp_limit);
      REG_BED_LIMIT:     prdata = 32'(cfg_q.bed_temp_limit);
      REG_TRAVEL_LIMIT:  prdata = 32'(cfg_q.travel_speed_limit);
      default:           prdata = '0;
    endcase
  end

  gmsc_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .cfg_i        (cfg_q),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  gmsc_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  gmsc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.issue_code == ISS_DONE) |-> out_data_o.last)
    else $error("done result without last");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !out_data_o.last |=> out_valid_o)
    else $error("result burst broken before last");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.issue_code != ISS_NO_HOME) &&
    (out_data_o.issue_code != ISS_NO_MOTION) && (out_data_o.issue_code != ISS_NO_LAYER) &&
    (out_data_o.issue_code != ISS_NO_EXTRUSION) && (out_data_o.issue_code != ISS_NO_LAYERS) &&
    (out_data_o.issue_code != ISS_NO_END) && (out_data_o.issue_code != ISS_DONE)
    |-> (out_data_o.line_number != '0))
    else $error("line issue with zero line number");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.overall_ok |-> (out_data_o.issue_code == ISS_DONE))
    else $error("overall ok on a non-done result");
`endif

endmodule
